### design/ddcu_pkg.sv
// Shared types, codes and helper functions for the differential drive command unit.
// No dependencies; used by ddcu_in_stage, ddcu_trim_mul, ddcu_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ddcu_pkg;

  // Command codes
  localparam logic [2:0] OP_DRIVE   = 3'd0;
  localparam logic [2:0] OP_REAPPLY = 3'd1;
  localparam logic [2:0] OP_ADJUST  = 3'd2;
  localparam logic [2:0] OP_TURN    = 3'd3;
  localparam logic [2:0] OP_PIVOT   = 3'd4;
  localparam logic [2:0] OP_BRAKE   = 3'd5;
  localparam logic [2:0] OP_COAST   = 3'd6;

  // Wheel select codes
  localparam logic [1:0] SEL_LEFT  = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_BOTH  = 2'd2;

  // Bridge modes
  localparam logic [1:0] MODE_COAST = 2'd0;
  localparam logic [1:0] MODE_FWD   = 2'd1;
  localparam logic [1:0] MODE_REV   = 2'd2;
  localparam logic [1:0] MODE_BRAKE = 2'd3;

  localparam int DUTY_MAX   = 255;
  localparam int TURN_LIMIT = 100;

  // x / 100 as (x * DIV_RECIP) >> DIV_SHIFT, exact for x below 2^17
  localparam int          DIV_SHIFT = 24;
  localparam logic [17:0] DIV_RECIP = 18'd167773;
  localparam int          MAGK_W    = 27;
  localparam int          PROD_W    = MAGK_W + 8;
  localparam int          QUOT_W    = PROD_W - DIV_SHIFT;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] duty;
  } bridge_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [1:0]        wheel_select;
    logic signed [9:0] value;
    logic [MAGK_W-1:0] mag_k;   // scaled |value| or |value/2|
  } cmd_reg_t;

  function automatic logic signed [8:0] sat_speed(input logic signed [9:0] v);
    logic signed [8:0] r;
    if (v > 10'(DUTY_MAX)) begin
      r = 9'(DUTY_MAX);
    end else if (v < -10'(DUTY_MAX)) begin
      r = -9'(DUTY_MAX);
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // Effective speed = set speed + trim, clamped; zero reads as reverse.
  function automatic bridge_t apply_wheel(input logic signed [8:0]  speed,
                                          input logic signed [11:0] trim);
    logic signed [12:0] eff;
    logic signed [12:0] clamped;
    logic signed [12:0] neg;
    bridge_t            b;
    eff = 13'(speed) + 13'(trim);
    if (eff > 13'(DUTY_MAX)) begin
      clamped = 13'(DUTY_MAX);
    end else if (eff < -13'(DUTY_MAX)) begin
      clamped = -13'(DUTY_MAX);
    end else begin
      clamped = eff;
    end
    neg = -clamped;
    if (clamped > 13'sd0) begin
      b.mode = MODE_FWD;
      b.duty = clamped[7:0];
    end else begin
      b.mode = MODE_REV;
      b.duty = neg[7:0];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### design/ddcu_cmd_if.sv
// Command channel: valid/ready handshake plus one command item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ddcu_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [1:0]        wheel_select;
  logic signed [9:0] value;

  modport source (output valid, output opcode, output wheel_select, output value,
                  input ready);
  modport sink   (input valid, input opcode, input wheel_select, input value,
                  output ready);
endinterface

`default_nettype wire

### design/ddcu_res_if.sv
// Result channel: valid/ready handshake plus one bridge report item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ddcu_res_if;
  logic              valid;
  logic              ready;
  logic [1:0]        left_mode;
  logic [7:0]        left_duty;
  logic [1:0]        right_mode;
  logic [7:0]        right_duty;
  logic signed [8:0] left_set_speed;
  logic signed [8:0] right_set_speed;
  logic signed [8:0] mean_set_speed;
  logic              status;

  modport source (output valid, output left_mode, output left_duty, output right_mode,
                  output right_duty, output left_set_speed, output right_set_speed,
                  output mean_set_speed, output status, input ready);
  modport sink   (input valid, input left_mode, input left_duty, input right_mode,
                  input right_duty, input left_set_speed, input right_set_speed,
                  input mean_set_speed, input status, output ready);
endinterface

`default_nettype wire

### design/ddcu_in_stage.sv
// Input register: captures a command item and the reciprocal-scaled magnitude.
// Depends on ddcu_pkg and ddcu_cmd_if.
`timescale 1ns / 1ps
`default_nettype none

module ddcu_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  ddcu_cmd_if.sink               cmd,
  input  wire logic              advance,
  output logic                   valid,
  output ddcu_pkg::cmd_reg_t     data
);

  logic [9:0]                  vmag;
  logic [9:0]                  mag_sel;
  logic [ddcu_pkg::MAGK_W-1:0] mag_k;

  // |value|; -512 fits as unsigned 512
  assign vmag    = cmd.value[9] ? 10'(-cmd.value) : 10'(cmd.value);
  // turn uses value/2 truncated toward zero
  assign mag_sel = (cmd.opcode == ddcu_pkg::OP_TURN) ? {1'b0, vmag[9:1]} : vmag;
  assign mag_k   = ddcu_pkg::MAGK_W'(28'(mag_sel) * 28'(ddcu_pkg::DIV_RECIP));

  assign cmd.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      data.opcode       <= cmd.opcode;
      data.wheel_select <= cmd.wheel_select;
      data.value        <= cmd.value;
      data.mag_k        <= mag_k;
    end
  end

endmodule

`default_nettype wire

### design/ddcu_trim_mul.sv
// Trim for one wheel: trunc(speed * factor / 100) from a pre-scaled factor magnitude.
// Depends on ddcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddcu_trim_mul (
  input  wire logic signed [8:0]                  speed,
  input  wire logic        [ddcu_pkg::MAGK_W-1:0] mag_k,
  input  wire logic                               factor_neg,
  output logic signed [11:0]                      trim
);

  logic [7:0]                  spd_mag;
  logic [ddcu_pkg::PROD_W-1:0] prod;
  logic [ddcu_pkg::QUOT_W-1:0] quot;

  assign spd_mag = speed[8] ? 8'(-speed) : speed[7:0];
  assign prod    = ddcu_pkg::PROD_W'(spd_mag) * ddcu_pkg::PROD_W'(mag_k);
  assign quot    = prod[ddcu_pkg::PROD_W-1:ddcu_pkg::DIV_SHIFT];
  // magnitude is zero whenever either sign is meaningless, so a plain xor suffices
  assign trim    = (speed[8] ^ factor_neg) ? -12'(quot) : 12'(quot);

endmodule

`default_nettype wire

### design/ddcu_core.sv
// Wheel state (set speeds, trims, bridges), command decode and result register.
// Depends on ddcu_pkg and ddcu_res_if.
`timescale 1ns / 1ps
`default_nettype none

module ddcu_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire ddcu_pkg::cmd_reg_t cmd,
  input  wire logic signed [11:0] left_trim_calc,
  input  wire logic signed [11:0] right_trim_calc,
  output logic                    advance,
  output logic                    left_factor_neg,
  output logic signed [8:0]       left_speed,
  output logic signed [8:0]       right_speed,
  ddcu_res_if.source              res
);

  logic signed [11:0] left_trim;
  logic signed [11:0] right_trim;
  ddcu_pkg::bridge_t  left_bridge;
  ddcu_pkg::bridge_t  right_bridge;

  logic signed [8:0]  left_speed_next;
  logic signed [8:0]  right_speed_next;
  logic signed [11:0] left_trim_next;
  logic signed [11:0] right_trim_next;
  ddcu_pkg::bridge_t  left_bridge_next;
  ddcu_pkg::bridge_t  right_bridge_next;
  logic               status_next;
  logic signed [9:0]  sum;

  logic               do_left;
  logic               do_right;
  logic [9:0]         vmag;
  logic signed [8:0]  speed_sat;
  logic [7:0]         pivot_duty;
  logic               turn_reject;

  assign advance = in_valid && (!res.valid || res.ready);

  // left trim factor is -adj on a turn
  assign left_factor_neg = (cmd.opcode == ddcu_pkg::OP_TURN) ? !cmd.value[9] : cmd.value[9];

  assign do_left  = (cmd.wheel_select == ddcu_pkg::SEL_LEFT)
                 || (cmd.wheel_select == ddcu_pkg::SEL_BOTH);
  assign do_right = (cmd.wheel_select == ddcu_pkg::SEL_RIGHT)
                 || (cmd.wheel_select == ddcu_pkg::SEL_BOTH);
  assign vmag        = cmd.value[9] ? 10'(-cmd.value) : 10'(cmd.value);
  assign speed_sat   = ddcu_pkg::sat_speed(cmd.value);
  assign pivot_duty  = (vmag > 10'(ddcu_pkg::DUTY_MAX)) ? 8'(ddcu_pkg::DUTY_MAX) : vmag[7:0];
  assign turn_reject = vmag[9:1] > 9'(ddcu_pkg::TURN_LIMIT);

  always_comb begin
    left_speed_next   = left_speed;
    right_speed_next  = right_speed;
    left_trim_next    = left_trim;
    right_trim_next   = right_trim;
    left_bridge_next  = left_bridge;
    right_bridge_next = right_bridge;
    status_next       = 1'b0;
    case (cmd.opcode)
      ddcu_pkg::OP_DRIVE: begin
        if (do_left) begin
          left_speed_next  = speed_sat;
          left_bridge_next = ddcu_pkg::apply_wheel(speed_sat, left_trim);
        end
        if (do_right) begin
          right_speed_next  = speed_sat;
          right_bridge_next = ddcu_pkg::apply_wheel(speed_sat, right_trim);
        end
      end
      ddcu_pkg::OP_REAPPLY: begin
        if (do_left) begin
          left_bridge_next = ddcu_pkg::apply_wheel(left_speed, left_trim);
        end
        if (do_right) begin
          right_bridge_next = ddcu_pkg::apply_wheel(right_speed, right_trim);
        end
      end
      ddcu_pkg::OP_ADJUST: begin
        if (do_left) begin
          left_trim_next   = left_trim_calc;
          left_bridge_next = ddcu_pkg::apply_wheel(left_speed, left_trim_calc);
        end
        if (do_right) begin
          right_trim_next   = right_trim_calc;
          right_bridge_next = ddcu_pkg::apply_wheel(right_speed, right_trim_calc);
        end
      end
      ddcu_pkg::OP_TURN: begin
        if (turn_reject) begin
          status_next = 1'b1;
        end else begin
          left_trim_next    = left_trim_calc;
          right_trim_next   = right_trim_calc;
          left_bridge_next  = ddcu_pkg::apply_wheel(left_speed, left_trim_calc);
          right_bridge_next = ddcu_pkg::apply_wheel(right_speed, right_trim_calc);
        end
      end
      ddcu_pkg::OP_PIVOT: begin
        left_bridge_next.mode  = cmd.value[9] ? ddcu_pkg::MODE_FWD : ddcu_pkg::MODE_REV;
        right_bridge_next.mode = cmd.value[9] ? ddcu_pkg::MODE_REV : ddcu_pkg::MODE_FWD;
        left_bridge_next.duty  = pivot_duty;
        right_bridge_next.duty = pivot_duty;
      end
      ddcu_pkg::OP_BRAKE: begin
        if (do_left) begin
          left_bridge_next = '{mode: ddcu_pkg::MODE_BRAKE, duty: 8'd0};
        end
        if (do_right) begin
          right_bridge_next = '{mode: ddcu_pkg::MODE_BRAKE, duty: 8'd0};
        end
      end
      ddcu_pkg::OP_COAST: begin
        if (do_left) begin
          left_bridge_next = '{mode: ddcu_pkg::MODE_COAST, duty: 8'd0};
        end
        if (do_right) begin
          right_bridge_next = '{mode: ddcu_pkg::MODE_COAST, duty: 8'd0};
        end
      end
      default: begin
      end
    endcase
  end

  assign sum = 10'(left_speed_next) + 10'(right_speed_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_speed   <= '0;
      right_speed  <= '0;
      left_trim    <= '0;
      right_trim   <= '0;
      left_bridge  <= '{mode: ddcu_pkg::MODE_COAST, duty: 8'd0};
      right_bridge <= '{mode: ddcu_pkg::MODE_COAST, duty: 8'd0};
      res.valid    <= 1'b0;
    end else if (advance) begin
      left_speed   <= left_speed_next;
      right_speed  <= right_speed_next;
      left_trim    <= left_trim_next;
      right_trim   <= right_trim_next;
      left_bridge  <= left_bridge_next;
      right_bridge <= right_bridge_next;
      res.valid    <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.left_mode       <= left_bridge_next.mode;
      res.left_duty       <= left_bridge_next.duty;
      res.right_mode      <= right_bridge_next.mode;
      res.right_duty      <= right_bridge_next.duty;
      res.left_set_speed  <= left_speed_next;
      res.right_set_speed <= right_speed_next;
      res.mean_set_speed  <= sum[9:1];
      res.status          <= status_next;
    end
  end

endmodule

`default_nettype wire

### design/differential_drive_command_unit.sv
// Differential drive command unit: one motor command in, one two-bridge report out.
// The accepted command is held in the input register, then the result register loads it
// once that register is empty or read at the same edge, and the report is offered from
// there. Throughput: one item per cycle while the result register is empty or read then.
// Reset (rst, synchronous): set speeds and trims zero, both bridges coast, duty zero,
// both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_command_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  ddcu_cmd_if.sink   cmd,
  ddcu_res_if.source res
);

  // Input stage -> core handoff
  logic               in_valid;
  ddcu_pkg::cmd_reg_t in_data;
  logic               advance;

  // Stored set speeds feed the trim multipliers; the core commits the results.
  logic signed [8:0]  left_speed;
  logic signed [8:0]  right_speed;
  logic signed [11:0] left_trim_calc;
  logic signed [11:0] right_trim_calc;
  logic               left_factor_neg;

  // Registers the command and precomputes |value| (or |value/2| on a turn)
  // times the reciprocal of 100, so only one multiply remains per wheel.
  ddcu_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .advance (advance),
    .valid   (in_valid),
    .data    (in_data)
  );

  // Left wheel: factor is the percent on adjust, -adj on a turn.
  ddcu_trim_mul u_trim_left (
    .speed      (left_speed),
    .mag_k      (in_data.mag_k),
    .factor_neg (left_factor_neg),
    .trim       (left_trim_calc)
  );

  // Right wheel: factor is the percent on adjust, +adj on a turn.
  ddcu_trim_mul u_trim_right (
    .speed      (right_speed),
    .mag_k      (in_data.mag_k),
    .factor_neg (in_data.value[9]),
    .trim       (right_trim_calc)
  );

  // Decode, wheel state update and result register. The result register
  // parts the two sides: a new command moves in while a result waits only
  // if that result is taken in the same cycle.
  ddcu_core u_core (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .cmd             (in_data),
    .left_trim_calc  (left_trim_calc),
    .right_trim_calc (right_trim_calc),
    .advance         (advance),
    .left_factor_neg (left_factor_neg),
    .left_speed      (left_speed),
    .right_speed     (right_speed),
    .res             (res)
  );

endmodule

`default_nettype wire
